// File: design/rpn_pkg.sv
// RPN calculator package: stack sizing, operation and status codes.
// No dependencies.
package rpn_pkg;
  localparam int StackDepth = 16;
  localparam int PtrW = $clog2(StackDepth);
  localparam int CntW = $clog2(StackDepth + 1);

  typedef enum logic [3:0] {
    OP_PUSH = 4'd0, OP_ADD = 4'd1, OP_SUB = 4'd2, OP_MUL = 4'd3, OP_DIV = 4'd4,
    OP_DROP = 4'd5, OP_CLEAR = 4'd6, OP_SWAP = 4'd7, OP_DUP = 4'd8,
    OP_TOP = 4'd9, OP_ALL = 4'd10
  } op_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_FEW = 3'd1, ST_EMPTY = 3'd2, ST_FULL = 3'd3,
    ST_DIV0 = 3'd4, ST_BAD = 3'd5
  } status_t;

  // datapath commands
  typedef enum logic [3:0] {
    DC_NONE, DC_RDA, DC_RDB, DC_ALU, DC_DIVSTART, DC_DIVSTEP,
    DC_WRRES, DC_WRSWAP, DC_WRSWB, DC_WRDUP, DC_PUSH, DC_DROP, DC_CLEAR, DC_SHOW
  } dcmd_t;

  typedef struct packed {
    dcmd_t cmd;
    logic [PtrW-1:0] addr;
  } ctl_t;

  typedef struct packed {
    logic [CntW-1:0] count;
    logic a_zero;
    logic div_done;
  } dstat_t;
endpackage

// File: design/rpn_datapath.sv
// RPN calculator datapath: stack memory, count, operand registers,
// adder/multiplier and a radix-2 restoring divider. Uses rpn_pkg.
module rpn_datapath import rpn_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  ctl_t        ctl,
  input  logic [3:0]  op_in,
  input  logic [31:0] val_in,
  output dstat_t      dst,
  output logic [31:0] rd_data
);
  logic [31:0] mem [StackDepth];
  logic [31:0] a, b, v, res;
  logic [3:0]  op;
  logic [CntW-1:0] count;
  logic [31:0] quo, rem, dvs;
  logic [5:0]  dcnt;
  logic        negq;
  logic [32:0] trial;

  assign dst.count = count;
  assign dst.a_zero = (a == 32'd0);
  assign dst.div_done = (dcnt == 6'd32);
  assign trial = {rem, quo[31]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      case (ctl.cmd)
        DC_PUSH, DC_WRDUP: count <= count + 1'b1;
        DC_WRRES, DC_DROP: count <= count - 1'b1;
        DC_CLEAR: count <= '0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    // token fields are captured at the accepting edge
    if (load) begin
      op <= op_in;
      v <= val_in;
    end
    case (ctl.cmd)
      DC_RDA: a <= rd_data;
      DC_RDB: b <= rd_data;
      DC_ALU: begin
        case (op)
          OP_ADD: res <= b + a;
          OP_SUB: res <= b - a;
          default: res <= b * a;
        endcase
      end
      DC_DIVSTART: begin
        quo <= b[31] ? -b : b;
        dvs <= a[31] ? -a : a;
        rem <= '0;
        negq <= a[31] ^ b[31];
        dcnt <= '0;
      end
      DC_DIVSTEP: begin
        if (dcnt == 6'd32) begin
          res <= negq ? -quo : quo;
        end else begin
          dcnt <= dcnt + 1'b1;
          if (!trial[32]) begin
            rem <= trial[31:0];
            quo <= {quo[30:0], 1'b1};
          end else begin
            rem <= {rem[30:0], quo[31]};
            quo <= {quo[30:0], 1'b0};
          end
        end
      end
      default: ;
    endcase
  end

  // memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    case (ctl.cmd)
      DC_PUSH: mem[ctl.addr] <= v;
      DC_WRRES: mem[ctl.addr] <= res;
      DC_WRSWAP: mem[ctl.addr] <= a;
      DC_WRSWB: mem[ctl.addr] <= b;
      DC_WRDUP: mem[ctl.addr] <= a;
      default: ;
    endcase
    rd_data <= mem[ctl.addr];
  end
endmodule

// File: design/rpn_ctrl.sv
// RPN calculator controller: sequences each operation over the datapath
// and drives the result strobe. Uses rpn_pkg.
module rpn_ctrl import rpn_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [3:0]  operation,
  output logic        busy,
  output logic        load,
  output ctl_t        ctl,
  input  dstat_t      dst,
  input  logic [31:0] rd_data,
  output logic        done,
  output logic [2:0]  status,
  output logic        has_value,
  output logic [31:0] shown_value,
  output logic        last
);
  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_RA, S_RB, S_GB, S_ALU, S_DIV, S_WR, S_SW2, S_TOPD, S_TOPW,
    S_ALLR, S_ALLD, S_ALLW
  } state_t;

  state_t state;
  logic [3:0] op;
  logic [CntW-1:0] n, k;
  logic [PtrW-1:0] top, sec;
  logic [CntW-1:0] nm1, nm2;

  assign nm1 = n - 1'b1;
  assign nm2 = n - 2'd2;
  assign top = nm1[PtrW-1:0];
  assign sec = nm2[PtrW-1:0];
  assign busy = (state != S_IDLE);
  assign load = start && (state == S_IDLE);

  task automatic emit(input logic [2:0] s, input logic h, input logic [31:0] d,
                      input logic l);
    done <= 1'b1;
    status <= s;
    has_value <= h;
    shown_value <= d;
    last <= l;
  endtask

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
      ctl <= '{cmd: DC_NONE, addr: '0};
    end else begin
      done <= 1'b0;
      ctl <= '{cmd: DC_NONE, addr: '0};
      case (state)
        S_IDLE: begin
          if (start) begin
            op <= operation;
            state <= S_DEC;
          end
        end
        S_DEC: begin
          n <= dst.count;
          k <= '0;
          state <= S_IDLE;
          case (op)
            OP_PUSH: begin
              if (dst.count == CntW'(StackDepth)) emit(ST_FULL, 1'b0, '0, 1'b1);
              else begin
                ctl <= '{cmd: DC_PUSH, addr: dst.count[PtrW-1:0]};
                emit(ST_OK, 1'b0, '0, 1'b1);
              end
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_SWAP, OP_DUP: begin
              if (dst.count == '0) emit(ST_EMPTY, 1'b0, '0, 1'b1);
              else if (dst.count == CntW'(1)) emit(ST_FEW, 1'b0, '0, 1'b1);
              else if (op == OP_DUP && dst.count == CntW'(StackDepth))
                emit(ST_FULL, 1'b0, '0, 1'b1);
              else state <= S_RA;
            end
            OP_DROP: begin
              if (dst.count == '0) emit(ST_EMPTY, 1'b0, '0, 1'b1);
              else begin
                ctl.cmd <= DC_DROP;
                emit(ST_OK, 1'b0, '0, 1'b1);
              end
            end
            OP_CLEAR: begin
              ctl.cmd <= DC_CLEAR;
              emit(ST_OK, 1'b0, '0, 1'b1);
            end
            OP_TOP: begin
              if (dst.count == '0) emit(ST_EMPTY, 1'b0, '0, 1'b1);
              else state <= S_RA;
            end
            OP_ALL: begin
              if (dst.count == '0) emit(ST_OK, 1'b0, '0, 1'b1);
              else state <= S_ALLR;
            end
            default: emit(ST_BAD, 1'b0, '0, 1'b1);
          endcase
        end
        S_RA: begin
          ctl.addr <= top;
          state <= (op == OP_TOP) ? S_TOPD : S_RB;
        end
        S_TOPD: begin
          // read data lands in the cycle after the address
          state <= S_TOPW;
        end
        S_TOPW: begin
          emit(ST_OK, 1'b1, rd_data, 1'b1);
          state <= S_IDLE;
        end
        S_RB: begin
          ctl <= '{cmd: DC_RDA, addr: sec};
          state <= S_GB;
        end
        S_GB: begin
          ctl.cmd <= DC_RDB;
          state <= S_ALU;
        end
        S_ALU: begin
          state <= S_WR;
          case (op)
            OP_SWAP: ctl <= '{cmd: DC_WRSWAP, addr: sec};
            OP_DUP: ctl <= '{cmd: DC_WRDUP, addr: n[PtrW-1:0]};
            OP_DIV: begin
              if (dst.a_zero) begin
                emit(ST_DIV0, 1'b0, '0, 1'b1);
                state <= S_IDLE;
              end else begin
                ctl.cmd <= DC_DIVSTART;
                state <= S_DIV;
              end
            end
            default: ctl.cmd <= DC_ALU;
          endcase
        end
        S_DIV: begin
          ctl.cmd <= DC_DIVSTEP;
          // step count is stale until the start command has executed
          if (dst.div_done && ctl.cmd == DC_DIVSTEP) state <= S_WR;
        end
        S_WR: begin
          state <= S_IDLE;
          case (op)
            OP_SWAP: begin
              state <= S_SW2;
            end
            OP_DUP: emit(ST_OK, 1'b0, '0, 1'b1);
            default: begin
              ctl <= '{cmd: DC_WRRES, addr: sec};
              emit(ST_OK, 1'b0, '0, 1'b1);
            end
          endcase
        end
        S_SW2: begin
          // top gets old second entry from operand register b
          ctl <= '{cmd: DC_WRSWB, addr: top};
          state <= S_IDLE;
          emit(ST_OK, 1'b0, '0, 1'b1);
        end
        S_ALLR: begin
          ctl.addr <= top - k[PtrW-1:0];
          state <= S_ALLD;
        end
        S_ALLD: begin
          state <= S_ALLW;
        end
        S_ALLW: begin
          emit(ST_OK, 1'b1, rd_data, (k + 1'b1) == n);
          k <= k + 1'b1;
          // address of the next entry goes out while this one is shown
          ctl.addr <= top - k[PtrW-1:0] - 1'b1;
          state <= ((k + 1'b1) == n) ? S_IDLE : S_ALLD;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: design/rpn_stack_calculator_unit.sv
// RPN stack calculator top level: controller plus datapath.
// Divide uses a 32-step divider. Show all gives one result per entry, top entry first,
// with last set on the final one. Next transaction is taken at the edge of the last
// result. Results are one-cycle strobes; no stall.
// Synchronous active-high reset empties the stack; entries stay unwritten.
module rpn_stack_calculator_unit import rpn_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  operation,
  input  logic signed [31:0] operand_value,
  output logic        done,
  output logic [2:0]  status,
  output logic        has_value,
  output logic signed [31:0] shown_value,
  output logic        last
);
  ctl_t ctl;
  dstat_t dst;
  logic [31:0] rd_data;
  logic load;

  rpn_ctrl u_ctrl (
    .clk, .rst, .start, .operation, .busy, .load, .ctl, .dst, .rd_data,
    .done, .status, .has_value, .shown_value, .last
  );

  rpn_datapath u_dp (
    .clk, .rst, .load, .ctl, .op_in(operation), .val_in(operand_value), .dst, .rd_data
  );
endmodule

// File: tb/rpn_stack_calculator_unit_test.sv
// Testbench for rpn_stack_calculator_unit: directed and random token streams,
// checked against a behavioral stack predictor. Depends on rpn_pkg.
`timescale 1ns / 100ps

module rpn_stack_calculator_unit_test;
  import rpn_pkg::*;

  typedef struct packed {
    logic [2:0]  status;
    logic        has_value;
    logic [31:0] shown_value;
    logic        last;
  } answer_t;

  localparam int CycleLimit = 400000;
  localparam logic [3:0] OpBad = 4'd11;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [3:0] operation = '0;
  logic signed [31:0] operand_value = '0;
  logic busy, done, has_value, last;
  logic [2:0] status;
  logic signed [31:0] shown_value;

  // predictor state
  logic [31:0] model_stack [StackDepth];
  int unsigned model_count;
  answer_t answers_due [$];
  int errors = 0;
  int unsigned cycles = 0;

  rpn_stack_calculator_unit DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .operation(operation),
    .operand_value(operand_value), .done(done), .status(status),
    .has_value(has_value), .shown_value(shown_value), .last(last)
  );

  always #4 clk = ~clk;

  function automatic answer_t mk_answer(logic [2:0] st, logic hv, logic [31:0] v, logic l);
    answer_t r;
    r.status = st;
    r.has_value = hv;
    r.shown_value = v;
    r.last = l;
    return r;
  endfunction

  function automatic logic [31:0] quotient_trunc(logic [31:0] b, logic [31:0] a);
    logic [31:0] mb, ma, q;
    mb = b[31] ? -b : b;
    ma = a[31] ? -a : a;
    q = mb / ma;
    return (b[31] != a[31]) ? -q : q;
  endfunction

  // apply one token to the predicted stack and queue its answers
  task automatic predict_token(logic [3:0] op, logic [31:0] v);
    logic [2:0] st;
    logic [31:0] a, b;
    int unsigned n;
    st = ST_OK;
    n = model_count;
    a = (n >= 1) ? model_stack[n-1] : '0;
    b = (n >= 2) ? model_stack[n-2] : '0;
    case (op)
      OP_PUSH: begin
        if (n >= StackDepth) st = ST_FULL;
        else begin
          model_stack[n] = v;
          model_count = n + 1;
        end
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_SWAP, OP_DUP: begin
        if (n == 0) st = ST_EMPTY;
        else if (n == 1) st = ST_FEW;
        else if (op == OP_SWAP) begin
          model_stack[n-1] = b;
          model_stack[n-2] = a;
        end else if (op == OP_DUP) begin
          if (n >= StackDepth) st = ST_FULL;
          else begin
            model_stack[n] = a;
            model_count = n + 1;
          end
        end else if (op == OP_DIV && a == 0) st = ST_DIV0;
        else begin
          case (op)
            OP_ADD: model_stack[n-2] = b + a;
            OP_SUB: model_stack[n-2] = b - a;
            OP_MUL: model_stack[n-2] = b * a;
            default: model_stack[n-2] = quotient_trunc(b, a);
          endcase
          model_count = n - 1;
        end
      end
      OP_DROP: begin
        if (n == 0) st = ST_EMPTY;
        else model_count = n - 1;
      end
      OP_CLEAR: model_count = 0;
      OP_TOP: begin
        if (n == 0) answers_due.push_back(mk_answer(ST_EMPTY, 1'b0, '0, 1'b1));
        else answers_due.push_back(mk_answer(ST_OK, 1'b1, a, 1'b1));
        return;
      end
      OP_ALL: begin
        if (n == 0) answers_due.push_back(mk_answer(ST_OK, 1'b0, '0, 1'b1));
        for (int k = 0; k < n; k++)
          answers_due.push_back(mk_answer(ST_OK, 1'b1, model_stack[n-1-k], k + 1 == n));
        return;
      end
      default: st = ST_BAD;
    endcase
    answers_due.push_back(mk_answer(st, 1'b0, '0, 1'b1));
  endtask

  // send one token; returns at the transaction edge with start still high
  task automatic send_token(logic [3:0] op, logic [31:0] v, bit allow_gap = 1'b1);
    int gap;
    gap = (allow_gap && $urandom_range(3) != 0) ? $urandom_range(19) : 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    operation <= op;
    operand_value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_token(op, v);
  endtask

  // result checker
  always @(posedge clk) begin
    answer_t exp_a;
    if (!rst && done) begin
      if (answers_due.size() == 0) begin
        $error("unexpected result: status %0d value %0d", status, shown_value);
        errors++;
      end else begin
        exp_a = answers_due.pop_front();
        if (status !== exp_a.status) begin
          $error("status: expected %0d, got %0d", exp_a.status, status);
          errors++;
        end
        if (has_value !== exp_a.has_value) begin
          $error("has_value: expected %0d, got %0d", exp_a.has_value, has_value);
          errors++;
        end
        if (shown_value !== exp_a.shown_value) begin
          $error("shown_value: expected %0d, got %0d", $signed(exp_a.shown_value),
                 shown_value);
          errors++;
        end
        if (last !== exp_a.last) begin
          $error("last: expected %0d, got %0d", exp_a.last, last);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'($urandom_range(7));
      4: return -32'($urandom_range(7));
      default: return $urandom;
    endcase
  endfunction

  task automatic test_empty_stack();
    for (int op = OP_ADD; op <= OP_ALL; op++) send_token(4'(op), '0);
    send_token(OpBad, '0);
    send_token(4'hf, 32'hffff_ffff);
  endtask

  task automatic test_single_entry();
    send_token(OP_PUSH, 32'h7fff_ffff);
    send_token(OP_ADD, '0);
    send_token(OP_DUP, '0);
    send_token(OP_SWAP, '0);
    send_token(OP_DIV, '0);
    send_token(OP_TOP, '0);
    send_token(OP_DROP, '0);
  endtask

  task automatic test_arith_corners();
    send_token(OP_PUSH, 32'h8000_0000);
    send_token(OP_PUSH, 32'hffff_ffff);
    send_token(OP_DIV, '0);            // most negative / -1 wraps
    send_token(OP_PUSH, '0);
    send_token(OP_DIV, '0);            // divide by zero
    send_token(OP_DROP, '0);
    send_token(OP_PUSH, 32'h7fff_ffff);
    send_token(OP_MUL, '0);
    send_token(OP_PUSH, 32'h5);
    send_token(OP_SUB, '0);
    send_token(OP_PUSH, 32'hffff_fffd);
    send_token(OP_SWAP, '0);
    send_token(OP_ALL, '0);
    send_token(OP_CLEAR, '0);
  endtask

  task automatic test_full_stack();
    for (int i = 0; i < StackDepth; i++) send_token(OP_PUSH, rand_operand(), 1'b0);
    send_token(OP_PUSH, 32'h1);
    send_token(OP_DUP, '0);
    send_token(OP_ALL, '0);
    send_token(OP_CLEAR, '0);
  endtask

  task automatic test_random_tokens(int count);
    logic [3:0] op;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(9))
        0, 1, 2: op = OP_PUSH;
        3, 4: op = 4'($urandom_range(OP_DIV, OP_ADD));
        5: op = 4'($urandom_range(OP_DUP, OP_DROP));
        6: op = ($urandom_range(7) == 0) ? OP_CLEAR : OP_SWAP;
        7: op = ($urandom_range(2) == 0) ? OP_ALL : OP_TOP;
        8: op = ($urandom_range(3) == 0) ? 4'($urandom_range(15, 11)) : OP_DUP;
        default: op = 4'($urandom_range(OP_DIV, OP_ADD));
      endcase
      send_token(op, rand_operand(), i % 40 < 30);
    end
  endtask

  initial begin
    model_count = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_stack();
    test_single_entry();
    test_arith_corners();
    test_full_stack();
    test_random_tokens(207);
    start <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0 && answers_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// File: files.f
design/rpn_pkg.sv
design/rpn_datapath.sv
design/rpn_ctrl.sv
design/rpn_stack_calculator_unit.sv
tb/rpn_stack_calculator_unit_test.sv
